// ----- rtl/dram_row_buffer_timing_defines.svh -----
// Assertion helpers shared by the row buffer timing RTL.
`ifndef DRAM_ROW_BUFFER_TIMING_DEFINES_SVH
`define DRAM_ROW_BUFFER_TIMING_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define DRBT_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define DRBT_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/drbt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package drbt_pkg;

    localparam int ROW_COUNT      = 256;
    localparam int WORDS_PER_ROW  = 256;
    localparam int BYTES_PER_WORD = 4;

    localparam int ROW_W      = $clog2(ROW_COUNT);
    localparam int COL_W      = $clog2(WORDS_PER_ROW);
    localparam int BYTE_OFS_W = $clog2(BYTES_PER_WORD);
    localparam int MEM_AW     = ROW_W + COL_W;
    localparam int MEM_DEPTH  = ROW_COUNT * WORDS_PER_ROW;

    localparam int OP_W      = 2;
    localparam int ADDR_W    = 18;
    localparam int DATA_W    = 32;
    localparam int TAG_W     = 5;
    localparam int DELAY_W   = 16;
    localparam int LAT_W     = 18;
    localparam int KIND_W    = 3;
    localparam int COUNT_W   = 32;
    localparam int CFG_IDX_W = 1;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    localparam logic [DELAY_W-1:0] ROW_DELAY_RESET    = 16'd10;
    localparam logic [DELAY_W-1:0] COLUMN_DELAY_RESET = 16'd2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_STORE = 2'd1,
        OP_FLUSH = 2'd2
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_HIT      = 3'd0,
        KIND_OPENED   = 3'd1,
        KIND_CONFLICT = 3'd2,
        KIND_FLUSHED  = 3'd3,
        KIND_IDLE     = 3'd4
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_DELAY    = 1'b0,
        CFG_COLUMN_DELAY = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        BK_CLEAR = 2'd0,
        BK_IDLE  = 2'd1,
        BK_READ  = 2'd2
    } back_state_t;

    typedef struct packed {
        logic               is_load;
        logic               is_store;
        logic [MEM_AW-1:0]  mem_addr;
        logic [DATA_W-1:0]  write_data;
        logic [TAG_W-1:0]   tag;
        logic [LAT_W-1:0]   latency;
        kind_t              kind;
        logic [COUNT_W-1:0] count;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

// ----- rtl/drbt_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface drbt_req_if import drbt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] byte_address;
    logic [DATA_W-1:0] write_data;
    logic [TAG_W-1:0]  dest_reg;

    modport source (output valid, output operation, output byte_address,
                    output write_data, output dest_reg, input ready);
    modport sink   (input valid, input operation, input byte_address,
                    input write_data, input dest_reg, output ready);
endinterface

interface drbt_rsp_if import drbt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DATA_W-1:0]  read_data;
    logic [TAG_W-1:0]   reg_tag;
    logic [LAT_W-1:0]   latency;
    logic [KIND_W-1:0]  access_kind;
    logic [COUNT_W-1:0] update_count;

    modport source (output valid, output read_data, output reg_tag, output latency,
                    output access_kind, output update_count, input ready);
    modport sink   (input valid, input read_data, input reg_tag, input latency,
                    input access_kind, input update_count, output ready);
endinterface

interface drbt_cfg_if import drbt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DELAY_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/drbt_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "dram_row_buffer_timing_defines.svh"

module drbt_queue import drbt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire q_entry_t push_entry,
    input  wire logic     pop,
    output q_entry_t      head,
    output q_status_t     status
);

    q_entry_t           entries_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_PTR_W:0]   count_reg;
    logic [Q_PTR_W:0]   count_next;

    assign status.full  = (count_reg == (Q_PTR_W + 1)'(Q_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `DRBT_ASSERT_IMPL(a_q_no_overflow, clk, rst_n, status.full, !push, "queue overflow")
    `DRBT_ASSERT_IMPL(a_q_no_underflow, clk, rst_n, status.empty, !pop, "queue underflow")

endmodule

`default_nettype wire

// ----- rtl/drbt_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "dram_row_buffer_timing_defines.svh"

module drbt_front import drbt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    drbt_req_if.sink       request,
    drbt_cfg_if.sink       cfg,
    input  wire logic      clear_done,
    input  wire q_status_t q_status,
    output logic           q_push,
    output q_entry_t       q_entry
);

    logic               row_open_reg;
    logic               row_open_next;
    logic [ROW_W-1:0]   open_row_reg;
    logic [ROW_W-1:0]   open_row_next;
    logic               dirty_reg;
    logic               dirty_next;
    logic [COUNT_W-1:0] total_reg;
    logic [COUNT_W-1:0] total_next;
    logic [DELAY_W-1:0] row_delay_reg;
    logic [DELAY_W-1:0] column_delay_reg;

    logic               accept;
    logic               is_load;
    logic               is_store;
    logic               is_access;
    logic               is_flush;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic               activate;
    logic [LAT_W-1:0]   rd_ext;
    logic [LAT_W-1:0]   cd_ext;
    logic [LAT_W-1:0]   base_lat;
    logic [LAT_W-1:0]   lat;
    kind_t              kind;
    logic [1:0]         inc;
    logic [COUNT_W:0]   sum;

    assign request.ready = clear_done && !q_status.full;
    assign cfg.ready     = 1'b1;
    assign accept        = request.valid && request.ready;

    assign is_load   = (request.operation == OP_LOAD);
    assign is_store  = (request.operation == OP_STORE);
    assign is_access = is_load || is_store;
    assign is_flush  = (request.operation == OP_FLUSH);

    // row wraps modulo the row count by taking only its low bits
    assign row = request.byte_address[BYTE_OFS_W + COL_W +: ROW_W];
    assign col = request.byte_address[BYTE_OFS_W +: COL_W];

    assign rd_ext = LAT_W'(row_delay_reg);
    assign cd_ext = LAT_W'(column_delay_reg);

    always_comb
    begin
        row_open_next = row_open_reg;
        open_row_next = open_row_reg;
        dirty_next    = dirty_reg;
        kind          = KIND_IDLE;
        base_lat      = '0;
        lat           = '0;
        activate      = 1'b0;
        if (is_access)
        begin
            if (!row_open_reg)
            begin
                kind          = KIND_OPENED;
                base_lat      = rd_ext;
                row_open_next = 1'b1;
                open_row_next = row;
                activate      = 1'b1;
            end
            else if (open_row_reg != row)
            begin
                // conflict always pays a writeback, clean or not
                kind          = KIND_CONFLICT;
                base_lat      = rd_ext << 1;
                dirty_next    = 1'b0;
                open_row_next = row;
                activate      = 1'b1;
            end
            else
            begin
                kind = KIND_HIT;
            end
            lat = base_lat + cd_ext;
            if (is_store)
            begin
                dirty_next = 1'b1;
            end
        end
        else if (is_flush && row_open_reg && dirty_reg)
        begin
            kind          = KIND_FLUSHED;
            lat           = rd_ext;
            row_open_next = 1'b0;
            dirty_next    = 1'b0;
        end
    end

    // up to two bumps per request: activate and store
    always_comb
    begin
        inc        = {1'b0, activate} + {1'b0, is_store};
        sum        = {1'b0, total_reg} + (COUNT_W + 1)'(inc);
        total_next = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
    end

    always_comb
    begin
        q_push              = accept;
        q_entry.is_load     = is_load;
        q_entry.is_store    = is_store;
        q_entry.mem_addr    = {row, col};
        q_entry.write_data  = request.write_data;
        q_entry.tag         = request.dest_reg;
        q_entry.latency     = lat;
        q_entry.kind        = kind;
        q_entry.count       = total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_open_reg <= 1'b0;
            open_row_reg <= '0;
            dirty_reg    <= 1'b0;
            total_reg    <= '0;
        end
        else if (accept)
        begin
            row_open_reg <= row_open_next;
            open_row_reg <= open_row_next;
            dirty_reg    <= dirty_next;
            total_reg    <= total_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_delay_reg    <= ROW_DELAY_RESET;
            column_delay_reg <= COLUMN_DELAY_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_ROW_DELAY:    row_delay_reg    <= cfg.data;
                CFG_COLUMN_DELAY: column_delay_reg <= cfg.data;
                default:          ;
            endcase
        end
    end

    `DRBT_ASSERT_IMPL(a_no_accept_clearing, clk, rst_n, !clear_done, !accept, "request taken during clear")
    `DRBT_ASSERT_NEXT(a_flush_closes, clk, rst_n, accept && is_flush && row_open_reg && dirty_reg, !row_open_reg && !dirty_reg, "dirty flush left row open")
    `DRBT_ASSERT_NEXT(a_count_rises, clk, rst_n, accept, total_reg >= $past(total_reg), "update count went down")

endmodule

`default_nettype wire

// ----- rtl/drbt_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "dram_row_buffer_timing_defines.svh"

module drbt_back import drbt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire q_status_t q_status,
    input  wire q_entry_t  head,
    output logic           q_pop,
    output logic           clear_done,
    drbt_rsp_if.source     result
);

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [MEM_AW-1:0]  clr_addr_reg;
    logic [MEM_AW-1:0]  clr_addr_next;
    q_entry_t           hold_reg;
    logic [DATA_W-1:0]  rd_data_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [DATA_W-1:0]  out_data_reg;
    logic [TAG_W-1:0]   out_tag_reg;
    logic [LAT_W-1:0]   out_lat_reg;
    kind_t              out_kind_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic [DATA_W-1:0]  mem [MEM_DEPTH];
    logic               mem_we;
    logic [MEM_AW-1:0]  mem_addr;
    logic [DATA_W-1:0]  mem_wdata;
    logic               can_pop;
    logic               load_out;

    // a pop is only taken once the output register is free by the next edge
    assign can_pop    = !q_status.empty && (!out_valid_reg || result.ready);
    assign clear_done = (state_reg != BK_CLEAR);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_CLEAR:
            begin
                if (clr_addr_reg == MEM_AW'(MEM_DEPTH - 1))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (can_pop)
                begin
                    state_next = BK_READ;
                end
            end
            BK_READ:  state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        mem_we        = 1'b0;
        mem_addr      = head.mem_addr;
        mem_wdata     = head.write_data;
        q_pop         = 1'b0;
        load_out      = 1'b0;
        clr_addr_next = clr_addr_reg;
        case (state_reg)
            BK_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_addr      = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            BK_IDLE:
            begin
                if (can_pop)
                begin
                    q_pop  = 1'b1;
                    mem_we = head.is_store;
                end
            end
            BK_READ:  load_out = 1'b1;
            default:  ;
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            hold_reg <= head;
        end
        if (load_out)
        begin
            out_data_reg  <= hold_reg.is_load ? rd_data_reg : '0;
            out_tag_reg   <= hold_reg.tag;
            out_lat_reg   <= hold_reg.latency;
            out_kind_reg  <= hold_reg.kind;
            out_count_reg <= hold_reg.count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_addr];
    end

    assign result.valid        = out_valid_reg;
    assign result.read_data    = out_data_reg;
    assign result.reg_tag      = out_tag_reg;
    assign result.latency      = out_lat_reg;
    assign result.access_kind  = out_kind_reg;
    assign result.update_count = out_count_reg;

    `DRBT_ASSERT_IMPL(a_no_pop_clearing, clk, rst_n, state_reg == BK_CLEAR, !q_pop && !out_valid_reg, "back end active during clear")

endmodule

`default_nettype wire

// ----- rtl/dram_row_buffer_timing.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Open-page DRAM row buffer timing block. After reset the word store is
// swept to zero, one word a cycle, while requests are held
// off (config writes are taken throughout). A request is classified
// against the open row in the cycle it is accepted and goes into a
// four-entry queue; the front keeps accepting while the queue has room.
// The back end then takes one request at a time: it pops the queue head and
// accesses the single-port word store, then loads the result register,
// and it pops another request only after that and once the result register
// is free or being taken.

module dram_row_buffer_timing import drbt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    drbt_req_if.sink   request,
    drbt_rsp_if.source result,
    drbt_cfg_if.sink   cfg
);

    logic      q_push;
    logic      q_pop;
    q_entry_t  push_entry;
    q_entry_t  head;
    q_status_t q_status;
    logic      clear_done;

    drbt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request),
        .cfg        (cfg),
        .clear_done (clear_done),
        .q_status   (q_status),
        .q_push     (q_push),
        .q_entry    (push_entry)
    );

    drbt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head       (head),
        .status     (q_status)
    );

    drbt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .head       (head),
        .q_pop      (q_pop),
        .clear_done (clear_done),
        .result     (result)
    );

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import drbt_pkg::*;

    // Operation code with no meaning; the block must treat it as an idle flush.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [DATA_W-1:0]  read_data;
        logic [TAG_W-1:0]   tag;
        logic [LAT_W-1:0]   latency;
        kind_t              kind;
        logic [COUNT_W-1:0] count;
    } access_outcome_t;

    class row_buffer_scoreboard;
        logic [DELAY_W-1:0] row_delay;
        logic [DELAY_W-1:0] column_delay;
        bit                 page_open;
        int unsigned        open_row;
        bit                 page_dirty;
        logic [COUNT_W-1:0] update_total;
        logic [DATA_W-1:0]  words [int unsigned];
        access_outcome_t    expected_q [$];
        int                 failures;

        function new();
            row_delay    = ROW_DELAY_RESET;
            column_delay = COLUMN_DELAY_RESET;
            page_open    = 1'b0;
            open_row     = 0;
            page_dirty   = 1'b0;
            update_total = '0;
            failures     = 0;
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            failures++;
        endtask

        function int pending();
            return expected_q.size();
        endfunction

        function void bump_total();
            if (update_total != '1)
                update_total++;
        endfunction

        // Works out the timing and data of one accepted request.
        function void note_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                   logic [DATA_W-1:0] wdata, logic [TAG_W-1:0] tag);
            int unsigned     word;
            int unsigned     row;
            int unsigned     key;
            access_outcome_t exp;
            word = addr / BYTES_PER_WORD;
            row  = (word / WORDS_PER_ROW) % ROW_COUNT;
            key  = row * WORDS_PER_ROW + word % WORDS_PER_ROW;
            exp.read_data = '0;
            exp.tag       = tag;
            exp.latency   = '0;
            exp.kind      = KIND_IDLE;
            if (op == OP_LOAD || op == OP_STORE) begin
                if (!page_open) begin
                    exp.kind    = KIND_OPENED;
                    exp.latency = LAT_W'(row_delay);
                    page_open   = 1'b1;
                    open_row    = row;
                    bump_total();
                end
                else if (open_row != row) begin
                    // old row written back even when clean
                    exp.kind    = KIND_CONFLICT;
                    exp.latency = LAT_W'(row_delay) + LAT_W'(row_delay);
                    page_dirty  = 1'b0;
                    open_row    = row;
                    bump_total();
                end
                else begin
                    exp.kind = KIND_HIT;
                end
                exp.latency = exp.latency + LAT_W'(column_delay);
                if (op == OP_LOAD) begin
                    if (words.exists(key))
                        exp.read_data = words[key];
                end
                else begin
                    words[key] = wdata;
                    bump_total();
                    page_dirty = 1'b1;
                end
            end
            else if (op == OP_FLUSH && page_open && page_dirty) begin
                exp.kind    = KIND_FLUSHED;
                exp.latency = LAT_W'(row_delay);
                page_open   = 1'b0;
                page_dirty  = 1'b0;
            end
            exp.count = update_total;
            expected_q = {expected_q, exp};
        endfunction

        task check_result(access_outcome_t got);
            access_outcome_t exp;
            if (expected_q.size() == 0) begin
                report("result with no request outstanding");
                return;
            end
            exp = expected_q.pop_front();
            if (got.read_data !== exp.read_data)
                report($sformatf("read_data %h, expected %h", got.read_data, exp.read_data));
            if (got.tag !== exp.tag)
                report($sformatf("reg_tag %0d, expected %0d", got.tag, exp.tag));
            if (got.latency !== exp.latency)
                report($sformatf("latency %0d, expected %0d", got.latency, exp.latency));
            if (got.kind !== exp.kind)
                report($sformatf("access_kind %0d, expected %0d", got.kind, exp.kind));
            if (got.count !== exp.count)
                report($sformatf("update_count %0d, expected %0d", got.count, exp.count));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    drbt_req_if request_ch ();
    drbt_rsp_if result_ch ();
    drbt_cfg_if cfg_ch ();

    dram_row_buffer_timing dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_ch),
        .result  (result_ch),
        .cfg     (cfg_ch)
    );

    row_buffer_scoreboard sb = new();

    int gap_pct   = 0;
    int stall_pct = 0;
    int stall_left = 0;
    int busy_levels [4] = '{0, 5, 20, 50};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        rst_n                   <= 1'b0;
        request_ch.valid        <= 1'b0;
        request_ch.operation    <= OP_LOAD;
        request_ch.byte_address <= '0;
        request_ch.write_data   <= '0;
        request_ch.dest_reg     <= '0;
        result_ch.ready         <= 1'b1;
        cfg_ch.valid            <= 1'b0;
        cfg_ch.index            <= CFG_ROW_DELAY;
        cfg_ch.data             <= '0;
    end

    // Result side: check every accepted result, stall in random bursts.
    initial
    begin
        access_outcome_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready) begin
                got.read_data = result_ch.read_data;
                got.tag       = result_ch.reg_tag;
                got.latency   = result_ch.latency;
                got.kind      = kind_t'(result_ch.access_kind);
                got.count     = result_ch.update_count;
                sb.check_result(got);
            end
            if (stall_left == 0 && stall_pct != 0 && $urandom_range(99) < stall_pct)
                stall_left = $urandom_range(14, 1);
            if (stall_left > 0) begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                                input logic [DATA_W-1:0] wdata, input logic [TAG_W-1:0] tag);
        request_ch.valid        <= 1'b1;
        request_ch.operation    <= op;
        request_ch.byte_address <= addr;
        request_ch.write_data   <= wdata;
        request_ch.dest_reg     <= tag;
        @(posedge clk);
        while (!request_ch.ready)
            @(posedge clk);
        sb.note_request(op, addr, wdata, tag);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            request_ch.valid <= 1'b0;
            repeat ($urandom_range(14, 1)) @(posedge clk);
        end
    endtask

    // Hold requests off until every outstanding request has its result.
    task automatic drain();
        request_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_delays(input logic [DELAY_W-1:0] rd, input logic [DELAY_W-1:0] cd);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_ROW_DELAY;
        cfg_ch.data  <= rd;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sb.row_delay = rd;
        cfg_ch.index <= CFG_COLUMN_DELAY;
        cfg_ch.data  <= cd;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sb.column_delay = cd;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly traffic on a few hot rows and columns so loads find stored data
    // and rows hit, conflict and flush often; the rest goes anywhere.
    task automatic random_traffic(input int count);
        int unsigned       hot [3];
        int unsigned       row;
        int unsigned       col;
        int                sent;
        int                pick;
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        foreach (hot[i])
            hot[i] = $urandom_range(ROW_COUNT - 1);
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                op = OP_LOAD;
            else if (pick < 75)
                op = OP_STORE;
            else if (pick < 94)
                op = OP_FLUSH;
            else
                op = OP_UNUSED;
            if ($urandom_range(99) < 85) begin
                row = hot[$urandom_range(2)];
                col = ($urandom_range(99) < 70) ? $urandom_range(7)
                                                : $urandom_range(WORDS_PER_ROW - 1);
                addr = ADDR_W'((row * WORDS_PER_ROW + col) * BYTES_PER_WORD
                               + $urandom_range(BYTES_PER_WORD - 1));
            end
            else begin
                addr = ADDR_W'($urandom_range(2 ** ADDR_W - 1));
            end
            send_request(op, addr, $urandom(), TAG_W'($urandom_range(31)));
            if (op != OP_UNUSED)
                sent++;
        end
    endtask

    task automatic set_busy();
        gap_pct   = busy_levels[$urandom_range(3)];
        stall_pct = busy_levels[$urandom_range(3)];
    endtask

    initial
    begin
        logic [DELAY_W-1:0] row_settings [5] = '{16'd0, 16'd65535, 16'd1, 16'd65535, 16'd10};
        logic [DELAY_W-1:0] col_settings [5] = '{16'd0, 16'd65535, 16'd65535, 16'd0, 16'd2};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        gap_pct   = 20;
        stall_pct = 20;

        // directed part under the reset delays
        send_request(OP_LOAD,   18'h00000, 32'h0000_0000, 5'd0);
        send_request(OP_FLUSH,  18'h00000, 32'h0000_0000, 5'd1);
        send_request(OP_STORE,  18'h3FFFF, 32'hFFFF_FFFF, 5'd31);
        send_request(OP_LOAD,   18'h3FFFC, 32'h0000_0000, 5'd2);
        send_request(OP_LOAD,   18'h3FFFF, 32'hFFFF_FFFF, 5'd31);
        send_request(OP_FLUSH,  18'h3FFFF, 32'h0000_0000, 5'd3);
        send_request(OP_FLUSH,  18'h00000, 32'h0000_0000, 5'd4);
        send_request(OP_UNUSED, 18'h3FFFF, 32'hFFFF_FFFF, 5'd31);
        send_request(OP_LOAD,   18'h3FFFD, 32'h0000_0000, 5'd5);
        send_request(OP_STORE,  18'h00400, 32'hA5A5_A5A5, 5'd6);
        send_request(OP_LOAD,   18'h00000, 32'h0000_0000, 5'd7);
        send_request(OP_FLUSH,  18'h00000, 32'h0000_0000, 5'd8);
        send_request(OP_LOAD,   18'h00004, 32'h0000_0000, 5'd9);
        send_request(OP_LOAD,   18'h00402, 32'h0000_0000, 5'd10);
        send_request(OP_STORE,  18'h00404, 32'h0000_0000, 5'd11);
        send_request(OP_FLUSH,  18'h00404, 32'h0000_0000, 5'd12);
        send_request(OP_UNUSED, 18'h00404, 32'h0000_0000, 5'd13);
        send_request(OP_STORE,  18'h2AAAA, 32'h5A5A_5A5A, 5'd21);
        send_request(OP_LOAD,   18'h15555, 32'h0000_0000, 5'd10);
        send_request(OP_LOAD,   18'h2AAA8, 32'h0000_0000, 5'd14);
        send_request(OP_FLUSH,  18'h00000, 32'h0000_0000, 5'd15);
        send_request(OP_LOAD,   18'h00403, 32'h0000_0000, 5'd16);

        // fixed settings, extremes among them
        foreach (row_settings[i])
        begin
            drain();
            write_delays(row_settings[i], col_settings[i]);
            set_busy();
            random_traffic(130);
        end

        for (int i = 0; i < 3; i++)
        begin
            drain();
            write_delays(DELAY_W'($urandom_range(65535)), DELAY_W'($urandom_range(65535)));
            set_busy();
            random_traffic(130);
        end

        // last stretch runs flat out on both sides
        drain();
        write_delays(DELAY_W'($urandom_range(40)), DELAY_W'($urandom_range(8)));
        gap_pct   = 0;
        stall_pct = 0;
        random_traffic(130);

        drain();
        repeat (20) @(posedge clk);
        if (sb.pending() != 0)
            sb.report("requests left without a result");
        if (sb.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
